>>> rtl/core/register_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// Register frame deframer - assertion macros
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// Every check is clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef REGISTER_FRAME_DEFRAMER_DEFINES_SVH
`define REGISTER_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that post holds in the same cycle as pre
`define RFD_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check that post holds in the cycle after pre
`define RFD_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define RFD_ASSERT_IMPLIES(label, pre, post, msg)
`define RFD_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

>>> rtl/core/rfd_pkg.sv
// ----------------------------------------------------------------------------
// Register frame deframer package
// Buffer sizing, frame constants and controller state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfd_pkg;

   // Receive buffer geometry
   localparam int BUF_DEPTH = 64;
   localparam int PTR_W     = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

   // Frame layout
   localparam int HDR_LEN   = 6;
   localparam int MIN_FRAME = 7;

   // Marker bytes
   localparam logic [7:0] START_CODE   = 8'h24;  // '$'
   localparam logic [7:0] HDR_END_CODE = 8'h23;  // '#'
   localparam logic [7:0] END_CODE     = 8'h40;  // '@'

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HDR_TEST,
      ST_HDR_A,
      ST_HDR_B,
      ST_END_TEST,
      ST_EMIT_RD,
      ST_EMIT_LD
   } rfd_state_type;

endpackage

>>> rtl/core/register_frame_deframer.sv
// ----------------------------------------------------------------------------
// Register frame deframer
// Buffers received bytes in a circular store, hunts for the six-byte header
// ('$', length, command, address, count, '#'), waits for the full frame and
// checks the closing '@'. A good frame leaves as one result per value byte,
// or one empty result; a bad end drops the header and the hunt resumes.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_rx_byte
//   rsp      out  rsp_valid/rsp_stall   frame fields, value byte, flags
//
// An accepted byte is written at the tail, then a scan step tests the
// buffer; a dropped byte passes through ST_HDR_TEST, a header match through
// ST_HDR_TEST, ST_HDR_A and ST_HDR_B, the end check through ST_END_TEST.
// Each result is a store read, then a load of the output register. The
// store is not cleared by reset. rsp_stall holds the emitter, and a new
// byte is taken while the last result of a frame still waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "register_frame_deframer_defines.svh"

module register_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_total_length,
   output logic [7:0] rsp_command_code,
   output logic [7:0] rsp_reg_address,
   output logic [7:0] rsp_reg_number,
   output logic [7:0] rsp_value_byte,
   output logic       rsp_value_valid,
   output logic       rsp_last_of_frame
);

   import rfd_pkg::*;

   rfd_state_type state_ff, state_in;

   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             hdr_seen_ff, hdr_seen_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       num_ff, num_in;
   logic [PTR_W-1:0] k_ff, k_in;

   logic [7:0]       byte_store_mem [BUF_DEPTH];
   logic [7:0]       rd_a_ff, rd_b_ff;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr_a, rd_addr_b;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;

   logic             out_valid_ff, out_valid_in;
   logic [6:0]       out_len_ff, out_len_in;
   logic [7:0]       out_cmd_ff, out_cmd_in;
   logic [7:0]       out_addr_ff, out_addr_in;
   logic [7:0]       out_num_ff, out_num_in;
   logic [7:0]       out_val_ff, out_val_in;
   logic             out_vvalid_ff, out_vvalid_in;
   logic             out_last_ff, out_last_in;

   logic             req_xfer;
   logic             out_free;
   logic             len_bad;
   logic             len_short;
   logic [7:0]       pay_len;
   logic             pay_empty;
   logic             emit_last;
   logic             head_ok;
   logic             end_ok;

   // Decode conditions
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign len_bad   = (int'(len_ff) < MIN_FRAME) || (int'(len_ff) > BUF_DEPTH);
   assign len_short = int'(count_ff) < int'(len_ff);
   assign pay_len   = len_ff - 8'(MIN_FRAME);
   assign pay_empty = (pay_len == 8'd0);
   assign emit_last = pay_empty || ((8'(k_ff) + 8'd1) == pay_len);
   assign head_ok   = (rd_a_ff == START_CODE) && (rd_b_ff == HDR_END_CODE);
   assign end_ok    = (rd_a_ff == END_CODE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hdr_seen_ff) begin
               if (len_bad)        state_in = ST_SCAN;
               else if (len_short) state_in = ST_IDLE;
               else                state_in = ST_END_TEST;
            end else if (int'(count_ff) < HDR_LEN) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HDR_TEST;
            end
         end
         ST_HDR_TEST: begin
            state_in = head_ok ? ST_HDR_A : ST_SCAN;
         end
         ST_HDR_A:    state_in = ST_HDR_B;
         ST_HDR_B:    state_in = ST_SCAN;
         ST_END_TEST: begin
            state_in = end_ok ? ST_EMIT_RD : ST_SCAN;
         end
         ST_EMIT_RD:  state_in = ST_EMIT_LD;
         ST_EMIT_LD: begin
            if (out_free) state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath control: buffer pointers, header capture, store access, output load
   always_comb begin
      rp_in         = rp_ff;
      count_in      = count_ff;
      hdr_seen_in   = hdr_seen_ff;
      len_in        = len_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      num_in        = num_ff;
      k_in          = k_ff;
      rd_en         = 1'b0;
      rd_addr_a     = rp_ff;
      rd_addr_b     = rp_ff + PTR_W'(HDR_LEN - 1);
      wr_en         = 1'b0;
      wr_addr       = rp_ff + PTR_W'(count_ff);
      out_valid_in  = out_valid_ff && rsp_stall;
      out_len_in    = out_len_ff;
      out_cmd_in    = out_cmd_ff;
      out_addr_in   = out_addr_ff;
      out_num_in    = out_num_ff;
      out_val_in    = out_val_ff;
      out_vvalid_in = out_vvalid_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            // Append the byte at the tail
            if (req_xfer && (int'(count_ff) < BUF_DEPTH)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_SCAN: begin
            if (hdr_seen_ff) begin
               if (len_bad) begin
                  // Drop the header
                  rp_in       = rp_ff + PTR_W'(HDR_LEN);
                  count_in    = count_ff - CNT_W'(HDR_LEN);
                  hdr_seen_in = 1'b0;
               end else if (!len_short) begin
                  rd_en     = 1'b1;
                  rd_addr_a = rp_ff + PTR_W'(len_ff - 8'd1);
               end
            end else if (int'(count_ff) >= HDR_LEN) begin
               // Fetch first and sixth byte
               rd_en = 1'b1;
            end
         end
         ST_HDR_TEST: begin
            if (head_ok) begin
               rd_en     = 1'b1;
               rd_addr_a = rp_ff + PTR_W'(1);
               rd_addr_b = rp_ff + PTR_W'(2);
            end else begin
               // Drop one byte and hunt on
               rp_in    = rp_ff + PTR_W'(1);
               count_in = count_ff - CNT_W'(1);
            end
         end
         ST_HDR_A: begin
            len_in    = rd_a_ff;
            cmd_in    = rd_b_ff;
            rd_en     = 1'b1;
            rd_addr_a = rp_ff + PTR_W'(3);
            rd_addr_b = rp_ff + PTR_W'(4);
         end
         ST_HDR_B: begin
            addr_in     = rd_a_ff;
            num_in      = rd_b_ff;
            hdr_seen_in = 1'b1;
         end
         ST_END_TEST: begin
            if (end_ok) begin
               k_in = '0;
            end else begin
               rp_in       = rp_ff + PTR_W'(HDR_LEN);
               count_in    = count_ff - CNT_W'(HDR_LEN);
               hdr_seen_in = 1'b0;
            end
         end
         ST_EMIT_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = rp_ff + PTR_W'(HDR_LEN) + k_ff;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_len_in    = len_ff[6:0];
               out_cmd_in    = cmd_ff;
               out_addr_in   = addr_ff;
               out_num_in    = num_ff;
               out_val_in    = pay_empty ? 8'd0 : rd_a_ff;
               out_vvalid_in = !pay_empty;
               out_last_in   = emit_last;
               k_in          = k_ff + PTR_W'(1);
               // Retire the whole frame after its last result
               if (emit_last) begin
                  rp_in       = rp_ff + PTR_W'(len_ff);
                  count_in    = count_ff - CNT_W'(len_ff);
                  hdr_seen_in = 1'b0;
               end
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         count_ff     <= '0;
         hdr_seen_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         hdr_seen_ff  <= hdr_seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Header fields, payload index and output payload
   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      num_ff        <= num_in;
      k_ff          <= k_in;
      out_len_ff    <= out_len_in;
      out_cmd_ff    <= out_cmd_in;
      out_addr_ff   <= out_addr_in;
      out_num_ff    <= out_num_in;
      out_val_ff    <= out_val_in;
      out_vvalid_ff <= out_vvalid_in;
      out_last_ff   <= out_last_in;
   end

   // Byte store: one write port, two registered read ports.
   // Writes happen only in the idle cycle and reads only later, so no overlap.
   always_ff @(posedge clock) begin
      if (wr_en) byte_store_mem[wr_addr] <= req_rx_byte;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= byte_store_mem[rd_addr_a];
         rd_b_ff <= byte_store_mem[rd_addr_b];
      end
   end

   // Drive the result port
   assign rsp_valid         = out_valid_ff;
   assign rsp_total_length  = out_len_ff;
   assign rsp_command_code  = out_cmd_ff;
   assign rsp_reg_address   = out_addr_ff;
   assign rsp_reg_number    = out_num_ff;
   assign rsp_value_byte    = out_val_ff;
   assign rsp_value_valid   = out_vvalid_ff;
   assign rsp_last_of_frame = out_last_ff;

   // Checks
   `RFD_ASSERT_IMPLIES(a_room_on_accept, req_xfer, int'(count_ff) < BUF_DEPTH,
      "accept with full buffer")
   `RFD_ASSERT_NEXT(a_count_on_accept, req_xfer,
      count_ff == $past(count_ff) + CNT_W'(1), "byte count did not advance")
   `RFD_ASSERT_IMPLIES(a_header_buffered, hdr_seen_ff, int'(count_ff) >= HDR_LEN,
      "header flag without header bytes")
   `RFD_ASSERT_IMPLIES(a_wait_full_frame, hdr_seen_ff && (state_ff == ST_IDLE),
      int'(count_ff) < int'(len_ff), "idle with a complete frame buffered")
   `RFD_ASSERT_IMPLIES(a_empty_is_last, rsp_valid && !rsp_value_valid, rsp_last_of_frame,
      "empty result not marked last")

endmodule
